FILE: hdl/tbb_pkg.sv
package tbb_pkg;

  // Fixed-point one in Q16.16.
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam int CoordWidthDef = 32;
  localparam int QueueDepth    = 4;
  localparam int NumRegs       = 6;
  localparam int RegIdxW       = 3;
  localparam int RegAddrW      = RegIdxW + 3;

  // Register indexes, eight bytes apart on the configuration port.
  localparam logic [RegIdxW-1:0] REG_ROW0_XY = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ROW0_ZT = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ROW1_XY = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ROW1_ZT = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ROW2_XY = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ROW2_ZT = 3'd5;

  // Identity transform after reset.
  localparam logic [63:0] ROW0_XY_RST = {32'h0, ONE_Q16};
  localparam logic [63:0] ROW0_ZT_RST = 64'h0;
  localparam logic [63:0] ROW1_XY_RST = {ONE_Q16, 32'h0};
  localparam logic [63:0] ROW1_ZT_RST = 64'h0;
  localparam logic [63:0] ROW2_XY_RST = 64'h0;
  localparam logic [63:0] ROW2_ZT_RST = {32'h0, ONE_Q16};

  // Matrix coefficients m[row][col] and translation t[row], all Q16.16.
  typedef struct packed {
    logic [2:0][2:0][31:0] m;
    logic [2:0][31:0]      t;
  } xform_t;

  // One vertex request after sign extension of its coordinates.
  typedef struct packed {
    logic [2:0][31:0] v;
    logic             first;
    logic             last;
  } vtx_t;

  // Coordinate width as used by the datapath: held between 16 and 32 bits.
  function automatic int cw_eff(input int w);
    int r;
    r = w;
    if (r > 32) r = 32;
    if (r < 16) r = 16;
    return r;
  endfunction

endpackage

FILE: hdl/transformed_bounding_box.sv
// Transformed bounding box: each request carries one vertex in signed Q16.16
// and flags that open (first_vertex) or close (last_vertex) a box. The vertex
// is put through the configured 3x3 matrix plus translation, the exact sum is
// rounded to nearest with ties toward plus infinity and saturated to
// COORD_WIDTH bits (held to the range 16..32), and the per-axis minimum and
// maximum are kept. A closing vertex produces one result with the box. The
// block takes one vertex per clock cycle while in_stall is low; nine parallel
// 32x32 multipliers and two compares per axis set that rate. An accepted
// closing vertex passes through the input queue, three datapath stages, then
// the box update that also loads the result register. A four-entry queue
// between the input side and the datapath absorbs stalls; while a result
// waits on out_stall the datapath holds and the queue keeps filling. The
// transform registers sit on the APB port at byte addresses 0, 8, ... 40
// and must only be written while no vertex is in flight.
module transformed_bounding_box #(
  parameter int COORD_WIDTH = tbb_pkg::CoordWidthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           in_vertex_x,
  input  logic signed [31:0]           in_vertex_y,
  input  logic signed [31:0]           in_vertex_z,
  input  logic                         in_first_vertex,
  input  logic                         in_last_vertex,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           out_min_x,
  output logic signed [31:0]           out_min_y,
  output logic signed [31:0]           out_min_z,
  output logic signed [31:0]           out_max_x,
  output logic signed [31:0]           out_max_y,
  output logic signed [31:0]           out_max_z,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tbb_pkg::RegAddrW-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import tbb_pkg::*;

  logic [63:0]        cfg_r [NumRegs];
  logic [RegIdxW-1:0] reg_idx;
  logic               reg_hit;
  logic               reg_wr;
  xform_t             xform;
  vtx_t               vtx;
  logic               vtx_valid;
  logic               vtx_take;
  logic [2:0][31:0]   box_lo;
  logic [2:0][31:0]   box_hi;

  // Registers are eight bytes apart; the low address bits are ignored and
  // writes past the last register are dropped.
  assign reg_idx = paddr[RegAddrW-1:3];
  assign reg_hit = (reg_idx < RegIdxW'(NumRegs));
  assign reg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? cfg_r[reg_idx] : 64'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_ROW0_XY] <= ROW0_XY_RST;
      cfg_r[REG_ROW0_ZT] <= ROW0_ZT_RST;
      cfg_r[REG_ROW1_XY] <= ROW1_XY_RST;
      cfg_r[REG_ROW1_ZT] <= ROW1_ZT_RST;
      cfg_r[REG_ROW2_XY] <= ROW2_XY_RST;
      cfg_r[REG_ROW2_ZT] <= ROW2_ZT_RST;
    end else if (reg_wr) begin
      cfg_r[reg_idx] <= pwdata;
    end
  end

  // Each row register pair holds the x and y coefficients, then the z
  // coefficient with the translation in the upper half.
  always_comb begin
    xform.m[0][0] = cfg_r[REG_ROW0_XY][31:0];
    xform.m[0][1] = cfg_r[REG_ROW0_XY][63:32];
    xform.m[0][2] = cfg_r[REG_ROW0_ZT][31:0];
    xform.t[0]    = cfg_r[REG_ROW0_ZT][63:32];
    xform.m[1][0] = cfg_r[REG_ROW1_XY][31:0];
    xform.m[1][1] = cfg_r[REG_ROW1_XY][63:32];
    xform.m[1][2] = cfg_r[REG_ROW1_ZT][31:0];
    xform.t[1]    = cfg_r[REG_ROW1_ZT][63:32];
    xform.m[2][0] = cfg_r[REG_ROW2_XY][31:0];
    xform.m[2][1] = cfg_r[REG_ROW2_XY][63:32];
    xform.m[2][2] = cfg_r[REG_ROW2_ZT][31:0];
    xform.t[2]    = cfg_r[REG_ROW2_ZT][63:32];
  end

  // Input side: accepts vertex requests, extends coordinates and queues them.
  tbb_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_vertex_z     (in_vertex_z),
    .in_first_vertex (in_first_vertex),
    .in_last_vertex  (in_last_vertex),
    .vtx_valid       (vtx_valid),
    .vtx_take        (vtx_take),
    .vtx             (vtx)
  );

  // Datapath: transform pipeline, running box and result register.
  tbb_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .xform     (xform),
    .vtx_valid (vtx_valid),
    .vtx       (vtx),
    .vtx_take  (vtx_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_lo    (box_lo),
    .out_hi    (box_hi)
  );

  assign out_min_x = $signed(box_lo[0]);
  assign out_min_y = $signed(box_lo[1]);
  assign out_min_z = $signed(box_lo[2]);
  assign out_max_x = $signed(box_hi[0]);
  assign out_max_y = $signed(box_hi[1]);
  assign out_max_z = $signed(box_hi[2]);

endmodule

FILE: hdl/tbb_front.sv
module tbb_front #(
  parameter int COORD_WIDTH = tbb_pkg::CoordWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic signed [31:0] in_vertex_z,
  input  logic               in_first_vertex,
  input  logic               in_last_vertex,
  output logic               vtx_valid,
  input  logic               vtx_take,
  output tbb_pkg::vtx_t      vtx
);
  import tbb_pkg::*;

  localparam int CwEff    = cw_eff(COORD_WIDTH);
  localparam int ExtShift = 32 - CwEff;
  localparam int PtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW     = $clog2(QueueDepth + 1);

  vtx_t            q_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;
  vtx_t            entry;

  // Keep the low CwEff bits and extend their top bit.
  function automatic logic [31:0] sext_coord(input logic [31:0] x);
    logic signed [31:0] s;
    s = $signed(x << ExtShift);
    return 32'(s >>> ExtShift);
  endfunction

  assign in_stall  = (cnt_r == CntW'(QueueDepth));
  assign vtx_valid = (cnt_r != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = vtx_take && vtx_valid;
  assign vtx       = q_r[rd_ptr_r];

  always_comb begin
    entry.v[0]  = sext_coord(in_vertex_x);
    entry.v[1]  = sext_coord(in_vertex_y);
    entry.v[2]  = sext_coord(in_vertex_z);
    entry.first = in_first_vertex;
    entry.last  = in_last_vertex;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= entry;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a lone push");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_take |-> (cnt_r != '0))
    else $error("back end took from an empty queue");

endmodule

FILE: hdl/tbb_back.sv
module tbb_back #(
  parameter int COORD_WIDTH = tbb_pkg::CoordWidthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbb_pkg::xform_t  xform,
  input  logic             vtx_valid,
  input  tbb_pkg::vtx_t    vtx,
  output logic             vtx_take,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0][31:0] out_lo,
  output logic [2:0][31:0] out_hi
);
  import tbb_pkg::*;

  localparam int CwEff = cw_eff(COORD_WIDTH);
  localparam logic signed [49:0] LimHi  = (50'sd1 <<< (CwEff - 1)) - 50'sd1;
  localparam logic signed [49:0] LimLo  = -LimHi - 50'sd1;
  localparam logic signed [64:0] HalfLsb = 65'sd32768;

  logic move;

  // Stage 1: nine products.
  logic               s1_valid_r, s1_first_r, s1_last_r;
  logic signed [63:0] s1_prod_r [3][3];
  logic signed [63:0] prod_nxt  [3][3];
  logic        [31:0] s1_t_r    [3];

  // Stage 2: two partial sums per axis, rounding half folded in.
  logic               s2_valid_r, s2_first_r, s2_last_r;
  logic signed [64:0] s2_ps_r [3];
  logic signed [64:0] s2_pt_r [3];
  logic signed [64:0] ps_nxt  [3];
  logic signed [64:0] pt_nxt  [3];

  // Stage 3: rounded and saturated coordinates.
  logic               s3_valid_r, s3_first_r, s3_last_r;
  logic signed [31:0] s3_p_r   [3];
  logic signed [31:0] p_nxt    [3];

  // Stage 4: running box and result register.
  logic signed [31:0] box_lo_r [3];
  logic signed [31:0] box_hi_r [3];
  logic signed [31:0] box_lo_nxt [3];
  logic signed [31:0] box_hi_nxt [3];
  logic               out_valid_r;
  logic [2:0][31:0]   out_lo_r, out_hi_r;

  assign move      = !(out_valid_r && out_stall);
  assign vtx_take  = move && vtx_valid;
  assign out_valid = out_valid_r;
  assign out_lo    = out_lo_r;
  assign out_hi    = out_hi_r;

  always_comb begin
    logic signed [31:0] coef;
    logic signed [31:0] crd;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef = $signed(xform.m[r][k]);
        crd  = $signed(vtx.v[k]);
        prod_nxt[r][k] = 64'(coef) * 64'(crd);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ps_nxt[r] = 65'(s1_prod_r[r][0]) + 65'(s1_prod_r[r][1]);
      pt_nxt[r] = 65'(s1_prod_r[r][2]) + 65'($signed({s1_t_r[r], 16'h0000})) + HalfLsb;
    end
  end

  always_comb begin
    logic signed [65:0] sum;
    logic signed [49:0] rnd;
    for (int r = 0; r < 3; r++) begin
      sum = 66'(s2_ps_r[r]) + 66'(s2_pt_r[r]);
      rnd = $signed(sum[65:16]);
      if (rnd > LimHi) p_nxt[r] = 32'(LimHi);
      else if (rnd < LimLo) p_nxt[r] = 32'(LimLo);
      else p_nxt[r] = 32'(rnd);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (s3_first_r) begin
        box_lo_nxt[a] = s3_p_r[a];
        box_hi_nxt[a] = s3_p_r[a];
      end else begin
        box_lo_nxt[a] = (s3_p_r[a] < box_lo_r[a]) ? s3_p_r[a] : box_lo_r[a];
        box_hi_nxt[a] = (s3_p_r[a] > box_hi_r[a]) ? s3_p_r[a] : box_hi_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
    end else if (move) begin
      s1_valid_r  <= vtx_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r && s3_last_r;
      if (s3_valid_r) begin
        for (int a = 0; a < 3; a++) begin
          box_lo_r[a] <= box_lo_nxt[a];
          box_hi_r[a] <= box_hi_nxt[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s1_first_r <= vtx.first;
      s1_last_r  <= vtx.last;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s3_first_r <= s2_first_r;
      s3_last_r  <= s2_last_r;
      for (int r = 0; r < 3; r++) begin
        s1_t_r[r] <= xform.t[r];
        s2_ps_r[r] <= ps_nxt[r];
        s2_pt_r[r] <= pt_nxt[r];
        s3_p_r[r]  <= p_nxt[r];
        for (int k = 0; k < 3; k++) begin
          s1_prod_r[r][k] <= prod_nxt[r][k];
        end
      end
      if (s3_valid_r && s3_last_r) begin
        for (int a = 0; a < 3; a++) begin
          out_lo_r[a] <= 32'(box_lo_nxt[a]);
          out_hi_r[a] <= 32'(box_hi_nxt[a]);
        end
      end
    end
  end

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r && s3_last_r))
    else $error("result raised without a last vertex in the final stage");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !vtx_take)
    else $error("queue popped while the result is held");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    (box_lo_r[0] <= box_hi_r[0]) && (box_lo_r[1] <= box_hi_r[1]) &&
    (box_lo_r[2] <= box_hi_r[2]))
    else $error("box minimum above maximum");

endmodule
